/* hdl/atk_pkg.sv */
// Shared types and constants for the assembly text tokenizer.
// Depends on nothing; used by every other file of the block.
package atk_pkg;

    localparam int unsigned DEF_MAX_TEXT_LEN = 65536;
    localparam int unsigned DEF_VALUE_BITS   = 32;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned NUM_W    = 32;
    localparam int unsigned OFS_W    = 16;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned RES_W    = KIND_W + NUM_W + OFS_W + LEN_W;
    localparam int unsigned OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int unsigned GRP_N    = 3;

    localparam logic [CH_W-1:0] C_NUL   = 8'h00;
    localparam logic [CH_W-1:0] C_SPACE = 8'h20;
    localparam logic [CH_W-1:0] C_TAB   = 8'h09;
    localparam logic [CH_W-1:0] C_LF    = 8'h0A;
    localparam logic [CH_W-1:0] C_VT    = 8'h0B;
    localparam logic [CH_W-1:0] C_FF    = 8'h0C;
    localparam logic [CH_W-1:0] C_CR    = 8'h0D;
    localparam logic [CH_W-1:0] C_COMMA = 8'h2C;
    localparam logic [CH_W-1:0] C_COLON = 8'h3A;
    localparam logic [CH_W-1:0] C_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] C_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] C_ONE   = 8'h31;
    localparam logic [CH_W-1:0] C_NINE  = 8'h39;
    localparam logic [CH_W-1:0] C_LO_A  = 8'h61;
    localparam logic [CH_W-1:0] C_LO_B  = 8'h62;
    localparam logic [CH_W-1:0] C_LO_F  = 8'h66;
    localparam logic [CH_W-1:0] C_LO_X  = 8'h78;
    localparam logic [CH_W-1:0] C_LO_Z  = 8'h7A;
    localparam logic [CH_W-1:0] C_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] C_UP_F  = 8'h46;
    localparam logic [CH_W-1:0] C_UP_Z  = 8'h5A;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        K_DIR   = 3'd0,
        K_IDENT = 3'd1,
        K_NUM   = 3'd2,
        K_SEP   = 3'd3,
        K_LABEL = 3'd4,
        K_ERR   = 3'd5,
        K_END   = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_DOT   = 4'd1,
        M_IDENT = 4'd2,
        M_ZERO  = 4'd3,
        M_BIN   = 4'd4,
        M_HEX   = 4'd5,
        M_DEC   = 4'd6,
        M_SKIP  = 4'd7
    } t_mode;

    typedef struct packed {
        t_kind             kind;
        logic [NUM_W-1:0]  value;
        logic [OFS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
    } t_result;

    typedef struct packed {
        logic [1:0]                cnt;
        t_result [GRP_N-1:0]       res;
    } t_group;

endpackage

/* hdl/atk_core.sv */
// Scanner state and per-character step logic of the tokenizer.
// Produces up to three results per character as one group. Uses atk_pkg.
module atk_core #(
    parameter int unsigned MAX_TEXT_LEN = atk_pkg::DEF_MAX_TEXT_LEN,
    parameter int unsigned VALUE_BITS   = atk_pkg::DEF_VALUE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [atk_pkg::CH_W-1:0]  i_ch,
    input  logic                      i_fin,
    output atk_pkg::t_group           o_grp
);

    localparam int unsigned POS_W = $clog2(MAX_TEXT_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT_LEN - 1);
    localparam logic [atk_pkg::LEN_W-1:0] LEN_W1 = atk_pkg::LEN_W'(1);

    atk_pkg::t_mode                r_mode, n_mode;
    logic                          r_dir, n_dir;
    logic [VALUE_BITS-1:0]         r_acc, n_acc;
    logic [POS_W-1:0]              r_start, n_start;
    logic [POS_W-1:0]              r_pos, n_pos;
    logic [atk_pkg::LEN_W-1:0]     r_len, n_len;

    atk_pkg::t_result [3:0]        cand;
    logic [3:0]                    cand_v;
    logic [2:0]                    cnt;
    logic [3:0]                    dig;
    logic [VALUE_BITS-1:0]         acc_dec, acc_hex, acc_bin;

    function automatic logic is_ws(input logic [atk_pkg::CH_W-1:0] c);
        return c == atk_pkg::C_SPACE || c == atk_pkg::C_TAB || c == atk_pkg::C_CR ||
               c == atk_pkg::C_LF || c == atk_pkg::C_VT || c == atk_pkg::C_FF;
    endfunction

    function automatic logic is_letter(input logic [atk_pkg::CH_W-1:0] c);
        return (c >= atk_pkg::C_LO_A && c <= atk_pkg::C_LO_Z) ||
               (c >= atk_pkg::C_UP_A && c <= atk_pkg::C_UP_Z);
    endfunction

    function automatic logic is_numeral(input logic [atk_pkg::CH_W-1:0] c);
        return c >= atk_pkg::C_ZERO && c <= atk_pkg::C_NINE;
    endfunction

    function automatic logic is_hexl(input logic [atk_pkg::CH_W-1:0] c);
        return (c >= atk_pkg::C_LO_A && c <= atk_pkg::C_LO_F) ||
               (c >= atk_pkg::C_UP_A && c <= atk_pkg::C_UP_F);
    endfunction

    function automatic logic is_term(input logic [atk_pkg::CH_W-1:0] c);
        return c == atk_pkg::C_NUL || is_ws(c) || c == atk_pkg::C_COMMA ||
               c == atk_pkg::C_COLON;
    endfunction

    function automatic logic [atk_pkg::OFS_W-1:0] ofs16(input logic [POS_W-1:0] p);
        logic [POS_W+atk_pkg::OFS_W-1:0] x;
        x = {{atk_pkg::OFS_W{1'b0}}, p};
        return x[atk_pkg::OFS_W-1:0];
    endfunction

    function automatic logic [atk_pkg::NUM_W-1:0] val32(input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS+atk_pkg::NUM_W-1:0] x;
        x = {{atk_pkg::NUM_W{1'b0}}, v};
        return x[atk_pkg::NUM_W-1:0];
    endfunction

    function automatic atk_pkg::t_result mk(input atk_pkg::t_kind k,
                                            input logic [atk_pkg::NUM_W-1:0] v,
                                            input logic [atk_pkg::OFS_W-1:0] s,
                                            input logic [atk_pkg::LEN_W-1:0] l);
        atk_pkg::t_result r;
        r.kind   = k;
        r.value  = v;
        r.start  = s;
        r.length = l;
        return r;
    endfunction

    function automatic logic [atk_pkg::LEN_W-1:0] bump(input logic [atk_pkg::LEN_W-1:0] l);
        return (l == atk_pkg::LEN_MAX) ? l : l + 1'b1;
    endfunction

    always_comb begin
        dig = i_ch[3:0];
        if (is_hexl(i_ch)) begin
            dig = i_ch[3:0] + 4'd9;
        end
        acc_dec = (r_acc << 3) + (r_acc << 1) + VALUE_BITS'(dig);
        acc_hex = (r_acc << 4) | VALUE_BITS'(dig);
        acc_bin = (r_acc << 1) | VALUE_BITS'(dig[0]);
    end

    always_comb begin
        n_mode  = r_mode;
        n_dir   = r_dir;
        n_acc   = r_acc;
        n_start = r_start;
        n_pos   = r_pos;
        n_len   = r_len;
        cand    = '0;
        cand_v  = '0;

        // close a token at a terminator
        if (i_ch == atk_pkg::C_NUL || (r_mode != atk_pkg::M_IDLE &&
                r_mode != atk_pkg::M_SKIP && is_term(i_ch))) begin
            unique case (r_mode)
                atk_pkg::M_DOT: begin
                    cand_v[0] = 1'b1;
                    cand[0]   = mk(atk_pkg::K_ERR, '0, ofs16(r_start), r_len);
                    n_mode    = atk_pkg::M_SKIP;
                end
                atk_pkg::M_IDENT: begin
                    cand_v[0] = 1'b1;
                    cand[0]   = mk(r_dir ? atk_pkg::K_DIR : atk_pkg::K_IDENT, '0,
                                   ofs16(r_start), r_len);
                    n_mode = atk_pkg::M_IDLE;
                    n_dir  = 1'b0;
                    n_acc  = '0;
                    n_len  = '0;
                end
                atk_pkg::M_ZERO, atk_pkg::M_BIN, atk_pkg::M_HEX, atk_pkg::M_DEC: begin
                    cand_v[0] = 1'b1;
                    cand[0]   = mk(atk_pkg::K_NUM, val32(r_acc), ofs16(r_start), r_len);
                    n_mode = atk_pkg::M_IDLE;
                    n_dir  = 1'b0;
                    n_acc  = '0;
                    n_len  = '0;
                end
                default: begin
                end
            endcase
        end

        if (i_ch == atk_pkg::C_NUL) begin
            cand_v[1] = 1'b1;
            cand[1]   = mk(atk_pkg::K_END, '0, ofs16(r_pos), '0);
            n_mode  = atk_pkg::M_IDLE;
            n_dir   = 1'b0;
            n_acc   = '0;
            n_start = '0;
            n_pos   = '0;
            n_len   = '0;
        end else begin
            unique case (n_mode)
                atk_pkg::M_IDLE: begin
                    priority if (is_ws(i_ch)) begin
                    end else if (i_ch == atk_pkg::C_COMMA) begin
                        cand_v[1] = 1'b1;
                        cand[1]   = mk(atk_pkg::K_SEP, '0, ofs16(r_pos), LEN_W1);
                    end else if (i_ch == atk_pkg::C_COLON) begin
                        cand_v[1] = 1'b1;
                        cand[1]   = mk(atk_pkg::K_LABEL, '0, ofs16(r_pos), LEN_W1);
                    end else if (i_ch == atk_pkg::C_DOT || is_letter(i_ch) ||
                                 is_numeral(i_ch)) begin
                        n_start = r_pos;
                        n_len   = LEN_W1;
                        n_acc   = '0;
                        n_dir   = 1'b0;
                        priority if (i_ch == atk_pkg::C_DOT) begin
                            n_mode = atk_pkg::M_DOT;
                            n_dir  = 1'b1;
                        end else if (is_letter(i_ch)) begin
                            n_mode = atk_pkg::M_IDENT;
                        end else if (i_ch == atk_pkg::C_ZERO) begin
                            n_mode = atk_pkg::M_ZERO;
                        end else begin
                            n_mode = atk_pkg::M_DEC;
                            n_acc  = VALUE_BITS'(dig);
                        end
                    end else begin
                        cand_v[1] = 1'b1;
                        cand[1]   = mk(atk_pkg::K_ERR, '0, ofs16(r_pos), LEN_W1);
                        n_mode    = atk_pkg::M_SKIP;
                    end
                end
                atk_pkg::M_DOT: begin
                    if (is_letter(i_ch)) begin
                        n_mode = atk_pkg::M_IDENT;
                        n_len  = bump(r_len);
                    end else begin
                        n_len     = bump(r_len);
                        cand_v[1] = 1'b1;
                        cand[1]   = mk(atk_pkg::K_ERR, '0, ofs16(r_start), bump(r_len));
                        n_mode    = atk_pkg::M_SKIP;
                    end
                end
                atk_pkg::M_IDENT: begin
                    n_len = bump(r_len);
                    if (!(is_letter(i_ch) || is_numeral(i_ch))) begin
                        cand_v[1] = 1'b1;
                        cand[1]   = mk(atk_pkg::K_ERR, '0, ofs16(r_start), bump(r_len));
                        n_mode    = atk_pkg::M_SKIP;
                    end
                end
                atk_pkg::M_ZERO: begin
                    n_len = bump(r_len);
                    priority if (i_ch == atk_pkg::C_LO_B) begin
                        n_mode = atk_pkg::M_BIN;
                    end else if (i_ch == atk_pkg::C_LO_X) begin
                        n_mode = atk_pkg::M_HEX;
                    end else if (is_numeral(i_ch)) begin
                        n_mode = atk_pkg::M_DEC;
                        n_acc  = acc_dec;
                    end else begin
                        cand_v[1] = 1'b1;
                        cand[1]   = mk(atk_pkg::K_ERR, '0, ofs16(r_start), bump(r_len));
                        n_mode    = atk_pkg::M_SKIP;
                    end
                end
                atk_pkg::M_BIN: begin
                    n_len = bump(r_len);
                    if (i_ch == atk_pkg::C_ZERO || i_ch == atk_pkg::C_ONE) begin
                        n_acc = acc_bin;
                    end else begin
                        cand_v[1] = 1'b1;
                        cand[1]   = mk(atk_pkg::K_ERR, '0, ofs16(r_start), bump(r_len));
                        n_mode    = atk_pkg::M_SKIP;
                    end
                end
                atk_pkg::M_HEX: begin
                    n_len = bump(r_len);
                    if (is_numeral(i_ch) || is_hexl(i_ch)) begin
                        n_acc = acc_hex;
                    end else begin
                        cand_v[1] = 1'b1;
                        cand[1]   = mk(atk_pkg::K_ERR, '0, ofs16(r_start), bump(r_len));
                        n_mode    = atk_pkg::M_SKIP;
                    end
                end
                atk_pkg::M_DEC: begin
                    n_len = bump(r_len);
                    if (is_numeral(i_ch)) begin
                        n_acc = acc_dec;
                    end else begin
                        cand_v[1] = 1'b1;
                        cand[1]   = mk(atk_pkg::K_ERR, '0, ofs16(r_start), bump(r_len));
                        n_mode    = atk_pkg::M_SKIP;
                    end
                end
                default: begin
                end
            endcase

            if (r_pos < POS_LAST) begin
                n_pos = r_pos + 1'b1;
            end

            if (i_fin) begin
                unique case (n_mode)
                    atk_pkg::M_DOT: begin
                        cand_v[2] = 1'b1;
                        cand[2]   = mk(atk_pkg::K_ERR, '0, ofs16(n_start), n_len);
                    end
                    atk_pkg::M_IDENT: begin
                        cand_v[2] = 1'b1;
                        cand[2]   = mk(n_dir ? atk_pkg::K_DIR : atk_pkg::K_IDENT, '0,
                                       ofs16(n_start), n_len);
                    end
                    atk_pkg::M_ZERO, atk_pkg::M_BIN, atk_pkg::M_HEX, atk_pkg::M_DEC: begin
                        cand_v[2] = 1'b1;
                        cand[2]   = mk(atk_pkg::K_NUM, val32(n_acc), ofs16(n_start), n_len);
                    end
                    default: begin
                    end
                endcase
                cand_v[3] = 1'b1;
                cand[3]   = mk(atk_pkg::K_END, '0, ofs16(n_pos), '0);
                n_mode  = atk_pkg::M_IDLE;
                n_dir   = 1'b0;
                n_acc   = '0;
                n_start = '0;
                n_pos   = '0;
                n_len   = '0;
            end
        end
    end

    // pack the valid candidates in order
    always_comb begin
        o_grp = '0;
        cnt   = '0;
        for (int k = 0; k < 4; k++) begin
            if (cand_v[k] && cnt < 3'(atk_pkg::GRP_N)) begin
                o_grp.res[cnt[1:0]] = cand[k];
                cnt = cnt + 1'b1;
            end
        end
        o_grp.cnt = cnt[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= atk_pkg::M_IDLE;
            r_dir   <= 1'b0;
            r_acc   <= '0;
            r_start <= '0;
            r_pos   <= '0;
            r_len   <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_dir   <= n_dir;
            r_acc   <= n_acc;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_len   <= n_len;
        end
    end

endmodule

/* hdl/atk_outbuf.sv */
// Result register of the tokenizer: holds one group of up to three tokens
// and hands them out one transaction at a time. Uses atk_pkg.
module atk_outbuf (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  atk_pkg::t_group                  i_grp,
    output logic                             o_free,
    output logic                             o_valid,
    input  logic                             i_ready,
    output atk_pkg::t_result                 o_res,
    output logic                             o_last
);

    atk_pkg::t_result [atk_pkg::GRP_N-1:0]   r_res;
    logic [1:0]                              r_cnt;
    logic [1:0]                              r_ptr;
    logic                                    pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_last  = (r_ptr == r_cnt - 2'd1);
    assign o_res   = r_res[r_ptr];
    assign pop     = o_valid && i_ready;
    assign o_free  = !o_valid || (pop && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ptr <= '0;
        end else begin
            if (i_load && i_grp.cnt != 2'd0) begin
                r_cnt <= i_grp.cnt;
                r_ptr <= '0;
            end else if (pop && o_last) begin
                r_cnt <= '0;
                r_ptr <= '0;
            end else if (pop) begin
                r_ptr <= r_ptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_grp.cnt != 2'd0) begin
            r_res <= i_grp.res;
        end
    end

endmodule

/* hdl/assembly_text_tokenizer.sv */
// Top level of the assembly text tokenizer: input register, scanner core
// and result register. Depends on atk_pkg, atk_core and atk_outbuf.
//
// Usage: text enters one byte per transaction on the slave channel, tlast
// marking the final byte of a text; a NUL byte also ends the text. Tokens
// leave on the master channel, one per transaction, tlast set on the last
// token caused by a given byte.
// An accepted byte waits in the input register and is scanned once the
// result register is free; its tokens then enter the result register, and
// the first is presented from there.
// Throughput: one byte per cycle while each byte causes at most one token
// and the receiver takes every token; a byte causing several tokens holds
// the result register until all have been taken (up to three per byte).
// Reset clears the scanner to the start of a new text at offset 0 and
// empties both registers. While the receiver stalls the result register
// holds its tokens; the input register takes one more byte and then the
// slave channel stops until the group has drained.
module assembly_text_tokenizer #(
    parameter int unsigned MAX_TEXT_LEN = atk_pkg::DEF_MAX_TEXT_LEN,
    parameter int unsigned VALUE_BITS   = atk_pkg::DEF_VALUE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [atk_pkg::CH_W-1:0]            i_s_tdata,   // [7:0] ch
    input  logic                                i_s_tlast,   // text_end
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [2:0] token_kind, [34:3] num_value, [50:35] start_offset,
    // [66:51] token_length, [71:67] zero
    output logic [atk_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tlast    // run_last
);

    logic                          r_in_valid;
    logic [atk_pkg::CH_W-1:0]      r_ch;
    logic                          r_fin;
    logic                          step;
    logic                          buf_free;
    atk_pkg::t_group               grp;
    atk_pkg::t_result              res;

    assign step       = r_in_valid && buf_free;
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_ch  <= i_s_tdata;
            r_fin <= i_s_tlast;
        end
    end

    atk_core #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN),
        .VALUE_BITS   (VALUE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_ch    (r_ch),
        .i_fin   (r_fin),
        .o_grp   (grp)
    );

    atk_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_grp   (grp),
        .o_free  (buf_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {{(atk_pkg::OUT_TDATA_W - atk_pkg::RES_W){1'b0}},
                        res.length, res.start, res.value, res.kind};

    a_end_of_text_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && (r_ch == atk_pkg::C_NUL || r_fin) |-> grp.cnt != 2'd0)
        else $error("end of text gave no tokens");

    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[atk_pkg::KIND_W-1:0] == atk_pkg::K_END |-> o_m_tlast)
        else $error("end-of-text token not last of its run");

    a_held_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !step |=> r_in_valid && $stable(r_ch) && $stable(r_fin))
        else $error("stalled input byte lost");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result presented after reset");

endmodule

/* test/atk_token_checker.sv */
// Token checker for the assembly text tokenizer: predicts the tokens of each
// accepted byte and compares them, in order, with the master channel.
// Depends on atk_pkg.
module atk_token_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [atk_pkg::CH_W-1:0]        i_s_tdata,   // [7:0] ch
    input  logic                            i_s_tlast,   // text_end
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // [2:0] token_kind, [34:3] num_value, [50:35] start_offset,
    // [66:51] token_length, [71:67] zero
    input  logic [atk_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                            i_m_tlast,   // run_last
    output int                              o_mismatches,
    output int                              o_pending
);
    import atk_pkg::*;

    typedef struct packed {
        t_kind             kind;
        logic [NUM_W-1:0]  value;
        logic [OFS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic              last;
    } t_token;

    t_token           pending_tokens[$];
    t_mode            scan;
    logic             dir_flag;
    logic [NUM_W-1:0] acc;
    int               tok_start;
    int               text_pos;
    int               tok_len;
    int               mism;
    int               n_checked;

    function automatic bit is_blank(input logic [CH_W-1:0] c);
        return c == C_SPACE || c == C_TAB || c == C_LF || c == C_VT || c == C_FF
            || c == C_CR;
    endfunction

    function automatic bit is_letter(input logic [CH_W-1:0] c);
        return (c >= C_LO_A && c <= C_LO_Z) || (c >= C_UP_A && c <= C_UP_Z);
    endfunction

    function automatic bit is_numeral(input logic [CH_W-1:0] c);
        return c >= C_ZERO && c <= C_NINE;
    endfunction

    function automatic bit is_stop(input logic [CH_W-1:0] c);
        return c == C_NUL || is_blank(c) || c == C_COMMA || c == C_COLON;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at token %0d: %s got %0h expected %0h",
                 n_checked, what, got, want);
        mism++;
    endtask

    task automatic push_token(input t_kind k, input logic [NUM_W-1:0] v, input int s,
                              input int l);
        t_token t;
        t.kind   = k;
        t.value  = v;
        t.start  = s[OFS_W-1:0];
        t.length = (l > LEN_MAX) ? LEN_MAX : l[LEN_W-1:0];
        t.last   = 1'b0;
        pending_tokens.push_back(t);
    endtask

    task automatic restart();
        scan      = M_IDLE;
        dir_flag  = 1'b0;
        acc       = '0;
        tok_start = 0;
        text_pos  = 0;
        tok_len   = 0;
    endtask

    task automatic open_token(input t_mode m, input int p);
        scan      = m;
        tok_start = p;
        tok_len   = 1;
        acc       = '0;
        dir_flag  = 1'b0;
    endtask

    task automatic grow_len();
        if (tok_len < LEN_MAX) tok_len++;
    endtask

    task automatic add_digit(input int base, input logic [CH_W-1:0] d);
        acc = acc * base + d;
    endtask

    task automatic fail_token();
        grow_len();
        push_token(K_ERR, '0, tok_start, tok_len);
        scan = M_SKIP;
    endtask

    task automatic close_open();
        bit closed;
        closed = 1'b1;
        case (scan)
            M_DOT: begin
                push_token(K_ERR, '0, tok_start, tok_len);
                scan   = M_SKIP;
                closed = 1'b0;
            end
            M_IDENT: push_token(dir_flag ? K_DIR : K_IDENT, '0, tok_start, tok_len);
            M_ZERO, M_BIN, M_HEX, M_DEC: push_token(K_NUM, acc, tok_start, tok_len);
            default: closed = 1'b0;
        endcase
        if (closed) begin
            scan     = M_IDLE;
            dir_flag = 1'b0;
            acc      = '0;
            tok_len  = 0;
        end
    endtask

    task automatic predict_tokens(input logic [CH_W-1:0] c, input logic fin);
        int     pos;
        int     first;
        t_token tail;
        pos   = text_pos;
        first = pending_tokens.size();
        if (c == C_NUL) begin
            close_open();
            push_token(K_END, '0, pos, 0);
            restart();
        end else begin
            if (scan != M_IDLE && scan != M_SKIP && is_stop(c)) close_open();
            case (scan)
                M_IDLE: begin
                    if (is_blank(c)) begin
                    end else if (c == C_COMMA) begin
                        push_token(K_SEP, '0, pos, 1);
                    end else if (c == C_COLON) begin
                        push_token(K_LABEL, '0, pos, 1);
                    end else if (c == C_DOT) begin
                        open_token(M_DOT, pos);
                        dir_flag = 1'b1;
                    end else if (is_letter(c)) begin
                        open_token(M_IDENT, pos);
                    end else if (c == C_ZERO) begin
                        open_token(M_ZERO, pos);
                    end else if (is_numeral(c)) begin
                        open_token(M_DEC, pos);
                        acc = NUM_W'(c - C_ZERO);
                    end else begin
                        push_token(K_ERR, '0, pos, 1);
                        scan = M_SKIP;
                    end
                end
                M_DOT: begin
                    if (is_letter(c)) begin
                        scan = M_IDENT;
                        grow_len();
                    end else fail_token();
                end
                M_IDENT: begin
                    if (is_letter(c) || is_numeral(c)) grow_len();
                    else fail_token();
                end
                M_ZERO: begin
                    if (c == C_LO_B) begin
                        scan = M_BIN;
                        grow_len();
                    end else if (c == C_LO_X) begin
                        scan = M_HEX;
                        grow_len();
                    end else if (is_numeral(c)) begin
                        scan = M_DEC;
                        add_digit(10, c - C_ZERO);
                        grow_len();
                    end else fail_token();
                end
                M_BIN: begin
                    if (c == C_ZERO || c == C_ONE) begin
                        add_digit(2, c - C_ZERO);
                        grow_len();
                    end else fail_token();
                end
                M_HEX: begin
                    if (is_numeral(c)) begin
                        add_digit(16, c - C_ZERO);
                        grow_len();
                    end else if (c >= C_LO_A && c <= C_LO_F) begin
                        add_digit(16, c - C_LO_A + 8'd10);
                        grow_len();
                    end else if (c >= C_UP_A && c <= C_UP_F) begin
                        add_digit(16, c - C_UP_A + 8'd10);
                        grow_len();
                    end else fail_token();
                end
                M_DEC: begin
                    if (is_numeral(c)) begin
                        add_digit(10, c - C_ZERO);
                        grow_len();
                    end else fail_token();
                end
                default: begin
                end
            endcase
            if (text_pos < DEF_MAX_TEXT_LEN - 1) text_pos++;
            if (fin) begin
                close_open();
                push_token(K_END, '0, text_pos, 0);
                restart();
            end
        end
        // mark the final token of this byte
        if (pending_tokens.size() > first) begin
            tail      = pending_tokens.pop_back();
            tail.last = 1'b1;
            pending_tokens.push_back(tail);
        end
    endtask

    task automatic check_token(input logic [OUT_TDATA_W-1:0] data, input logic last);
        t_token want;
        if (pending_tokens.size() == 0) begin
            report_mismatch("token with none pending, kind", data[KIND_W-1:0], '0);
        end else begin
            want = pending_tokens.pop_front();
            if (data[KIND_W-1:0] !== want.kind)
                report_mismatch("token_kind", data[KIND_W-1:0], want.kind);
            if (data[KIND_W +: NUM_W] !== want.value)
                report_mismatch("num_value", data[KIND_W +: NUM_W], want.value);
            if (data[KIND_W+NUM_W +: OFS_W] !== want.start)
                report_mismatch("start_offset", data[KIND_W+NUM_W +: OFS_W], want.start);
            if (data[KIND_W+NUM_W+OFS_W +: LEN_W] !== want.length)
                report_mismatch("token_length", data[KIND_W+NUM_W+OFS_W +: LEN_W],
                                want.length);
            if (last !== want.last)
                report_mismatch("run_last", last, want.last);
        end
        n_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart();
            pending_tokens.delete();
            mism      = 0;
            n_checked = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) predict_tokens(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) check_token(i_m_tdata, i_m_tlast);
        end
        o_mismatches <= mism;
        o_pending    <= pending_tokens.size();
    end

endmodule

/* test/tb_assembly_text_tokenizer.sv */
// Testbench top for the assembly text tokenizer: clock, reset, byte stimulus,
// receiver back-pressure, watchdog and verdict.
// Depends on atk_pkg, assembly_text_tokenizer and atk_token_checker.
module tb_assembly_text_tokenizer;
    import atk_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_BYTES = 90;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CH_W-1:0]        s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    int quiet         = 0;
    int bytes_sent    = 0;
    int idle_tab[4]   = '{0, 50, 0, 9};
    int stall_tab[4]  = '{0, 0, 50, 9};

    string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string alnum   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    string numerals = "0123456789";
    string hexdig  = "0123456789abcdefABCDEF";

    assembly_text_tokenizer i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    atk_token_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else quiet <= quiet + 1;
    end

    function automatic logic [CH_W-1:0] pick(input string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    task automatic send_char(input logic [CH_W-1:0] c, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_str(input string txt, input logic fin_on_last);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], fin_on_last && (i == txt.len() - 1));
    endtask

    task automatic send_random_text();
        logic [CH_W-1:0] text_q[$];
        int              ntok;
        int              ending;
        ntok = $urandom_range(1, 6);
        for (int t = 0; t < ntok; t++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    text_q.push_back(pick(letters));
                    repeat ($urandom_range(0, 6)) text_q.push_back(pick(alnum));
                end
                2: begin
                    text_q.push_back(C_DOT);
                    text_q.push_back(pick(letters));
                    repeat ($urandom_range(0, 5)) text_q.push_back(pick(alnum));
                end
                3: repeat ($urandom_range(1, 12)) text_q.push_back(pick(numerals));
                4: begin
                    text_q.push_back(C_ZERO);
                    text_q.push_back(C_LO_B);
                    repeat ($urandom_range(0, 40))
                        text_q.push_back($urandom_range(0, 1) ? C_ONE : C_ZERO);
                end
                5: begin
                    text_q.push_back(C_ZERO);
                    text_q.push_back(C_LO_X);
                    repeat ($urandom_range(0, 12)) text_q.push_back(pick(hexdig));
                end
                6: text_q.push_back(C_COMMA);
                7: text_q.push_back(C_COLON);
                8: text_q.push_back(C_ZERO);
                default: text_q.push_back(C_DOT);
            endcase
            case ($urandom_range(0, 7))
                0: text_q.push_back(C_SPACE);
                1: text_q.push_back(C_TAB);
                2: text_q.push_back(C_LF);
                3: text_q.push_back(C_VT);
                4: text_q.push_back(C_FF);
                5: text_q.push_back(C_CR);
                6: text_q.push_back(C_COMMA);
                default: text_q.push_back(C_COLON);
            endcase
        end
        // corrupt one byte now and then
        if ($urandom_range(0, 7) == 0)
            text_q[$urandom_range(0, text_q.size() - 1)] = CH_W'($urandom_range(1, 255));
        ending = $urandom_range(0, 2);
        if (ending == 1 && text_q.size() > 1 && $urandom_range(0, 1)) void'(text_q.pop_back());
        if (ending != 1) text_q.push_back(C_NUL);
        foreach (text_q[i]) send_char(text_q[i], ending != 0 && i == text_q.size() - 1);
    endtask

    initial begin
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_str(".d Z9,0b1:07 0", 1'b1);
        send_str("0xFFFFFFFFF", 1'b1);
        send_str("0x\t0b", 1'b0);
        send_char(C_NUL, 1'b0);
        send_str(".,", 1'b0);
        send_char(C_NUL, 1'b1);
        send_char(C_LO_A, 1'b0);
        send_char(8'h80, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(C_DOT, 1'b1);
        send_char(C_DOT, 1'b1);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_tab[p];
            stall_pct     = stall_tab[p];
            if (p == 0) hold_req = 1'b1;
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) send_random_text();
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        send_char(C_SPACE, 1'b0);
        send_char(C_NINE, 1'b1);
        send_random_text();
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
